// ===== design/partially_matched_crossover_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the crossover unit
// Shared forms for the concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef PARTIALLY_MATCHED_CROSSOVER_UNIT_MACROS_SVH
`define PARTIALLY_MATCHED_CROSSOVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMX_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMX_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/pmx_pkg.sv =====
// ----------------------------------------------------------------------------
// pmx_pkg
// Types and constants shared by the crossover controller and datapath.
// ----------------------------------------------------------------------------
package pmx_pkg;

  // Fixed field widths.
  localparam int PNT_W = 5;
  localparam int POS_W = 5;
  localparam int CL_W  = 6;
  localparam int NP_W  = 5;
  localparam int CFG_W = 6;

  // Configuration register indexes and reset values.
  localparam logic CFG_IDX_LENGTH = 1'b0;
  localparam logic CFG_IDX_POINTS = 1'b1;
  localparam logic [CL_W-1:0] CL_RESET = 6'd32;
  localparam logic [NP_W-1:0] NP_RESET = 5'd1;

  // Input item kinds and result status codes.
  localparam logic KIND_POINT      = 1'b0;
  localparam logic KIND_GENE       = 1'b1;
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SWP_RD, ST_SWP_WR, ST_DK_RD, ST_DK_LD, ST_DJ_RD, ST_DJ_CMP,
    ST_K_NEXT, ST_CHECK, ST_RP_LRD, ST_RP_GRD, ST_RP_WR, ST_EM_RD, ST_EM_OUT,
    ST_ERR
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_IDLE, OP_SWP_RD, OP_SWP_WR, OP_DK_RD, OP_DK_LD, OP_DJ_RD,
    OP_DJ_CMP, OP_K_NEXT, OP_RP_LRD, OP_RP_GRD, OP_RP_WR, OP_EM_RD, OP_EM_OUT,
    OP_ERR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic accept;
  } pmx_cmd_t;

  typedef struct packed {
    logic k_last;
    logic dk_last;
    logic skip_k;
    logic j_end;
    logic cnt_eq;
    logic cnt_zero;
    logic rp_last;
  } pmx_stat_t;

endpackage

// ===== design/pmx_ctrl.sv =====
// ----------------------------------------------------------------------------
// pmx_ctrl
// Sequencer for loading, segment swap, duplicate search, repair and output.
// ----------------------------------------------------------------------------
module pmx_ctrl
  import pmx_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      in_kind,
  input  logic      in_last,
  input  pmx_stat_t stat,
  output pmx_cmd_t  cmd,
  output logic      busy
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (in_kind == KIND_GENE) && in_last) state_nxt = ST_SWP_RD;
      end
      ST_SWP_RD: state_nxt = ST_SWP_WR;
      ST_SWP_WR: state_nxt = stat.k_last ? ST_DK_RD : ST_SWP_RD;
      ST_DK_RD:  state_nxt = ST_DK_LD;
      ST_DK_LD:  state_nxt = stat.skip_k ? ST_K_NEXT : ST_DJ_RD;
      ST_DJ_RD:  state_nxt = ST_DJ_CMP;
      ST_DJ_CMP: state_nxt = stat.j_end ? ST_K_NEXT : ST_DJ_RD;
      ST_K_NEXT: state_nxt = stat.dk_last ? ST_CHECK : ST_DK_RD;
      ST_CHECK: begin
        priority if (!stat.cnt_eq) state_nxt = ST_ERR;
        else if (stat.cnt_zero)    state_nxt = ST_EM_RD;
        else                       state_nxt = ST_RP_LRD;
      end
      ST_RP_LRD: state_nxt = ST_RP_GRD;
      ST_RP_GRD: state_nxt = ST_RP_WR;
      ST_RP_WR:  state_nxt = stat.rp_last ? ST_EM_RD : ST_RP_LRD;
      ST_EM_RD:  state_nxt = ST_EM_OUT;
      ST_EM_OUT: state_nxt = stat.k_last ? ST_IDLE : ST_EM_RD;
      ST_ERR:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.accept = (state_r == ST_IDLE) && start;
    busy       = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:   cmd.op = OP_IDLE;
      ST_SWP_RD: cmd.op = OP_SWP_RD;
      ST_SWP_WR: cmd.op = OP_SWP_WR;
      ST_DK_RD:  cmd.op = OP_DK_RD;
      ST_DK_LD:  cmd.op = OP_DK_LD;
      ST_DJ_RD:  cmd.op = OP_DJ_RD;
      ST_DJ_CMP: cmd.op = OP_DJ_CMP;
      ST_K_NEXT: cmd.op = OP_K_NEXT;
      ST_RP_LRD: cmd.op = OP_RP_LRD;
      ST_RP_GRD: cmd.op = OP_RP_GRD;
      ST_RP_WR:  cmd.op = OP_RP_WR;
      ST_EM_RD:  cmd.op = OP_EM_RD;
      ST_EM_OUT: cmd.op = OP_EM_OUT;
      ST_ERR:    cmd.op = OP_ERR;
      default:   cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== design/pmx_datapath.sv =====
// ----------------------------------------------------------------------------
// pmx_datapath
// Gene and duplicate-list memories, cut points, counters and result registers.
// ----------------------------------------------------------------------------
module pmx_datapath
  import pmx_pkg::*;
#(
  parameter int MAX_LENGTH = 32,
  parameter int GENE_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pmx_cmd_t             cmd,
  output pmx_stat_t            stat,
  input  logic                 in_kind,
  input  logic [PNT_W-1:0]     in_point,
  input  logic [GENE_BITS-1:0] in_gene_a,
  input  logic [GENE_BITS-1:0] in_gene_b,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 out_strobe,
  output logic [POS_W-1:0]     out_position,
  output logic [GENE_BITS-1:0] out_child_a,
  output logic [GENE_BITS-1:0] out_child_b,
  output logic                 out_changed,
  output logic                 out_status,
  output logic                 out_end_of_run
);

  localparam int AW   = $clog2(MAX_LENGTH);
  localparam int LW   = $clog2(MAX_LENGTH + 1);
  localparam int NCUT = MAX_LENGTH / 2;
  localparam int PCW  = $clog2(NCUT + 1);
  localparam int CIW  = (NCUT > 1) ? $clog2(NCUT) : 1;
  localparam int XW   = (LW > CFG_W) ? LW : CFG_W;

  // Configuration and control registers.
  logic [CL_W-1:0]       cl_r;
  logic [NP_W-1:0]       np_r;
  logic [AW-1:0]         k_r, j_r, cnt_a_r, cnt_b_r;
  logic [LW-1:0]         lc_r;
  logic [PCW-1:0]        pc_r;
  logic                  swap_r, act_a_r, act_b_r, strobe_r;
  logic [MAX_LENGTH-1:0] mark_a_r, mark_b_r;

  // Payload registers.
  logic [PNT_W-1:0]     cut_r [NCUT];
  logic [GENE_BITS-1:0] rd_a_r, rd_b_r, key_a_r, key_b_r;
  logic [AW-1:0]        la_r, lb_r;
  logic [POS_W-1:0]     pos_r;
  logic [GENE_BITS-1:0] ca_r, cb_r;
  logic                 chg_r, st_r, end_r;

  // Memories.
  logic [GENE_BITS-1:0] gene_a_mem [MAX_LENGTH];
  logic [GENE_BITS-1:0] gene_b_mem [MAX_LENGTH];
  logic [AW-1:0]        list_a_mem [MAX_LENGTH];
  logic [AW-1:0]        list_b_mem [MAX_LENGTH];

  logic [XW-1:0] cl_x, len_x, half_x, effp_x, n_x, len_m1_x, len_m2_x;
  logic          pt_take, gn_take, par, match_a, match_b;
  logic                 ga_we, gb_we;
  logic [AW-1:0]        ga_waddr, gb_waddr, ga_raddr, gb_raddr;
  logic [GENE_BITS-1:0] ga_wdata, gb_wdata;

  // Effective length, point limit and point count in use.
  always_comb begin
    cl_x = XW'(cl_r);
    priority if (cl_x < XW'(2))          len_x = XW'(2);
    else if (cl_x > XW'(MAX_LENGTH))     len_x = XW'(MAX_LENGTH);
    else                                 len_x = cl_x;
    half_x   = len_x >> 1;
    effp_x   = (XW'(np_r) > half_x) ? half_x : XW'(np_r);
    n_x      = (XW'(pc_r) > half_x) ? half_x : XW'(pc_r);
    len_m1_x = len_x - XW'(1);
    len_m2_x = len_x - XW'(2);
  end

  assign pt_take = cmd.accept && (in_kind == KIND_POINT) && (XW'(pc_r) < effp_x);
  assign gn_take = cmd.accept && (in_kind == KIND_GENE) && (XW'(lc_r) < len_x);

  // A position is swapped when an odd number of cut points lie at or below it.
  always_comb begin
    par = 1'b0;
    for (int i = 0; i < NCUT; i++) begin
      if ((XW'(i) < n_x) && (XW'(cut_r[i]) <= XW'(k_r))) par = ~par;
    end
  end

  // Duplicate match of the scanned word against each side's key.
  assign match_a = act_a_r && !mark_a_r[j_r] && (rd_a_r == key_a_r);
  assign match_b = act_b_r && !mark_b_r[j_r] && (rd_b_r == key_b_r);

  // Status to the controller.
  always_comb begin
    stat.k_last   = (XW'(k_r) == len_m1_x);
    stat.dk_last  = (XW'(k_r) == len_m2_x);
    stat.skip_k   = mark_a_r[k_r] && mark_b_r[k_r];
    stat.j_end    = (XW'(j_r) == len_m1_x) ||
                    ((!act_a_r || match_a) && (!act_b_r || match_b));
    stat.cnt_eq   = (cnt_a_r == cnt_b_r);
    stat.cnt_zero = (cnt_a_r == '0);
    stat.rp_last  = (k_r == (cnt_a_r - AW'(1)));
  end

  // Gene memory port selection.
  always_comb begin
    ga_we    = 1'b0;
    gb_we    = 1'b0;
    ga_waddr = k_r;
    gb_waddr = k_r;
    ga_wdata = rd_b_r;
    gb_wdata = rd_a_r;
    ga_raddr = k_r;
    gb_raddr = k_r;
    unique case (cmd.op)
      OP_IDLE: begin
        ga_we    = gn_take;
        gb_we    = gn_take;
        ga_waddr = AW'(lc_r);
        gb_waddr = AW'(lc_r);
        ga_wdata = in_gene_a;
        gb_wdata = in_gene_b;
      end
      OP_SWP_WR: begin
        ga_we    = 1'b1;
        gb_we    = 1'b1;
        ga_wdata = par ? rd_b_r : rd_a_r;
        gb_wdata = par ? rd_a_r : rd_b_r;
      end
      OP_DJ_RD: begin
        ga_raddr = j_r;
        gb_raddr = j_r;
      end
      OP_RP_GRD: begin
        ga_raddr = la_r;
        gb_raddr = lb_r;
      end
      OP_RP_WR: begin
        ga_we    = 1'b1;
        gb_we    = 1'b1;
        ga_waddr = la_r;
        gb_waddr = lb_r;
      end
      default: begin
      end
    endcase
  end

  // Memories with registered reads.
  always_ff @(posedge clk) begin
    if (ga_we) gene_a_mem[ga_waddr] <= ga_wdata;
    if (gb_we) gene_b_mem[gb_waddr] <= gb_wdata;
    rd_a_r <= gene_a_mem[ga_raddr];
    rd_b_r <= gene_b_mem[gb_raddr];
    if ((cmd.op == OP_DJ_CMP) && match_a) list_a_mem[cnt_a_r] <= j_r;
    if ((cmd.op == OP_DJ_CMP) && match_b) list_b_mem[cnt_b_r] <= j_r;
    la_r <= list_a_mem[k_r];
    lb_r <= list_b_mem[k_r];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cl_r     <= CL_RESET;
      np_r     <= NP_RESET;
      k_r      <= '0;
      j_r      <= '0;
      cnt_a_r  <= '0;
      cnt_b_r  <= '0;
      lc_r     <= '0;
      pc_r     <= '0;
      swap_r   <= 1'b0;
      act_a_r  <= 1'b0;
      act_b_r  <= 1'b0;
      strobe_r <= 1'b0;
      mark_a_r <= '0;
      mark_b_r <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_LENGTH) cl_r <= cfg_data[CL_W-1:0];
        else                             np_r <= cfg_data[NP_W-1:0];
      end
      strobe_r <= (cmd.op == OP_EM_OUT) || (cmd.op == OP_ERR);
      unique case (cmd.op)
        OP_IDLE: begin
          k_r <= '0;
          if (pt_take) pc_r <= pc_r + PCW'(1);
          if (gn_take) lc_r <= lc_r + LW'(1);
        end
        OP_SWP_WR: begin
          if (par && (rd_a_r != rd_b_r)) swap_r <= 1'b1;
          k_r <= stat.k_last ? '0 : k_r + AW'(1);
        end
        OP_DK_LD: begin
          act_a_r <= !mark_a_r[k_r];
          act_b_r <= !mark_b_r[k_r];
          j_r     <= k_r + AW'(1);
        end
        OP_DJ_CMP: begin
          if (match_a) begin
            mark_a_r[j_r] <= 1'b1;
            cnt_a_r       <= cnt_a_r + AW'(1);
            act_a_r       <= 1'b0;
          end
          if (match_b) begin
            mark_b_r[j_r] <= 1'b1;
            cnt_b_r       <= cnt_b_r + AW'(1);
            act_b_r       <= 1'b0;
          end
          j_r <= j_r + AW'(1);
        end
        OP_K_NEXT: k_r <= stat.dk_last ? '0 : k_r + AW'(1);
        OP_RP_WR:  k_r <= stat.rp_last ? '0 : k_r + AW'(1);
        OP_EM_OUT, OP_ERR: begin
          k_r <= k_r + AW'(1);
          if (stat.k_last || (cmd.op == OP_ERR)) begin
            lc_r     <= '0;
            pc_r     <= '0;
            swap_r   <= 1'b0;
            cnt_a_r  <= '0;
            cnt_b_r  <= '0;
            mark_a_r <= '0;
            mark_b_r <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cut points, scan keys and result word.
  always_ff @(posedge clk) begin
    if (pt_take) cut_r[CIW'(pc_r)] <= in_point;
    if (cmd.op == OP_DK_LD) begin
      key_a_r <= rd_a_r;
      key_b_r <= rd_b_r;
    end
    if (cmd.op == OP_EM_OUT) begin
      pos_r <= POS_W'(k_r);
      ca_r  <= rd_a_r;
      cb_r  <= rd_b_r;
      chg_r <= swap_r;
      st_r  <= STATUS_OK;
      end_r <= stat.k_last;
    end else if (cmd.op == OP_ERR) begin
      pos_r <= '0;
      ca_r  <= '0;
      cb_r  <= '0;
      chg_r <= 1'b0;
      st_r  <= STATUS_MISMATCH;
      end_r <= 1'b1;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_position   = pos_r;
  assign out_child_a    = ca_r;
  assign out_child_b    = cb_r;
  assign out_changed    = chg_r;
  assign out_status     = st_r;
  assign out_end_of_run = end_r;

endmodule

// ===== design/partially_matched_crossover_unit.sv =====
// ----------------------------------------------------------------------------
// partially_matched_crossover_unit
// Partially matched crossover of one parent pair with duplicate repair.
//
// Channel   Handshake            Contents
// input     start / busy         kind, point, gene_a, gene_b, last
// result    out_strobe           position, child_a, child_b, flags, status
// config    cfg_we               cfg_index, cfg_data
//
// Point and gene words are taken only while the unit is idle. The gene word with
// last set starts a run: segment swap, a duplicate scan over each start position
// with its compares, a count check, repair of each duplicate pair, then the
// emitted results, or a single error result when the duplicate counts differ.
// Reset is synchronous and active low. Results cannot be held off.
// ----------------------------------------------------------------------------
module partially_matched_crossover_unit
  import pmx_pkg::*;
#(
  parameter int MAX_LENGTH = 32,
  parameter int GENE_BITS  = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_kind,
  input  logic [PNT_W-1:0]     in_point,
  input  logic [GENE_BITS-1:0] in_gene_a,
  input  logic [GENE_BITS-1:0] in_gene_b,
  input  logic                 in_last,
  output logic                 out_strobe,
  output logic [POS_W-1:0]     out_position,
  output logic [GENE_BITS-1:0] out_child_a,
  output logic [GENE_BITS-1:0] out_child_b,
  output logic                 out_changed,
  output logic                 out_status,
  output logic                 out_end_of_run,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  pmx_cmd_t  cmd;
  pmx_stat_t stat;

  // Sequencer.
  pmx_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .in_last (in_last),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Storage and arithmetic.
  pmx_datapath #(
    .MAX_LENGTH (MAX_LENGTH),
    .GENE_BITS  (GENE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_kind        (in_kind),
    .in_point       (in_point),
    .in_gene_a      (in_gene_a),
    .in_gene_b      (in_gene_b),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_strobe     (out_strobe),
    .out_position   (out_position),
    .out_child_a    (out_child_a),
    .out_child_b    (out_child_b),
    .out_changed    (out_changed),
    .out_status     (out_status),
    .out_end_of_run (out_end_of_run)
  );

endmodule

// ===== design/pmx_checker.sv =====
// ----------------------------------------------------------------------------
// pmx_checker
// Port-level checks on the crossover unit, bound to its top level.
// ----------------------------------------------------------------------------
`include "partially_matched_crossover_unit_macros.svh"

module pmx_checker
  import pmx_pkg::*;
#(
  parameter int GENE_BITS = 8
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 in_kind,
  input logic                 in_last,
  input logic                 out_strobe,
  input logic [POS_W-1:0]     out_position,
  input logic [GENE_BITS-1:0] out_child_a,
  input logic [GENE_BITS-1:0] out_child_b,
  input logic                 out_status,
  input logic                 out_end_of_run
);

  // A point word never starts a run.
  `PMX_ASSERT_NEXT(a_point_stays_idle, clk, rst_n, start && !busy && (in_kind == KIND_POINT), !busy, "point word made the unit busy")
  // The final gene word starts a run.
  `PMX_ASSERT_NEXT(a_last_starts_run, clk, rst_n, start && !busy && (in_kind == KIND_GENE) && in_last, busy, "final gene word did not start a run")
  // An error result is the only and last word of its run.
  `PMX_ASSERT_NOW(a_error_ends_run, clk, rst_n, out_strobe && (out_status == STATUS_MISMATCH), out_end_of_run && (out_position == '0) && (out_child_a == '0) && (out_child_b == '0), "malformed error word")
  // No result strobe of a run is followed directly by another.
  `PMX_ASSERT_NEXT(a_strobe_spacing, clk, rst_n, out_strobe && !out_end_of_run, !out_strobe, "back-to-back result strobes")

endmodule

bind partially_matched_crossover_unit pmx_checker #(
  .GENE_BITS (GENE_BITS)
) u_pmx_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .in_kind        (in_kind),
  .in_last        (in_last),
  .out_strobe     (out_strobe),
  .out_position   (out_position),
  .out_child_a    (out_child_a),
  .out_child_b    (out_child_b),
  .out_status     (out_status),
  .out_end_of_run (out_end_of_run)
);
